// File: hdl/tts_pkg.sv
// Package: sizes, codes and types for the thread table scheduler.
`default_nettype none
package tts_pkg;
  localparam int MaxSlots   = 8;
  localparam int NumSems    = 8;
  localparam int QueueDepth = 8;
  localparam int IdWidth    = 16;

  localparam int FuncW  = 3;
  localparam int StatW  = 3;
  localparam int SemIdW = 3;
  localparam int CntW   = 8;
  localparam int ValW   = 32;
  localparam int TidW   = 16;
  localparam int RslotW = 3;

  typedef enum logic [2:0] {
    FN_CREATE = 3'd0, FN_YIELD = 3'd1, FN_EXIT = 3'd2, FN_JOIN = 3'd3,
    FN_SINIT = 3'd4, FN_SWAIT = 3'd5, FN_SPOST = 3'd6, FN_NOP = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NO_SLOT = 3'd1, ST_NOT_FOUND = 3'd2, ST_BLOCKED = 3'd3,
    ST_QFULL = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    TS_UNUSED = 3'd0, TS_RUNNABLE = 3'd1, TS_RUNNING = 3'd2, TS_SLEEPING = 3'd3,
    TS_ZOMBIE = 3'd4
  } tstate_e;

  typedef enum logic [2:0] {
    FS_IDLE, FS_SCAN, FS_QRD, FS_QSHIFT, FS_RESCHED, FS_OUT
  } fsm_e;
endpackage
`default_nettype wire

// File: hdl/tts_if.sv
// Valid/ready channel interfaces for request and result items.
`default_nettype none
interface tts_req_if;
  logic                       valid;
  logic                       ready;
  logic [tts_pkg::FuncW-1:0]  func;
  logic [tts_pkg::TidW-1:0]   target_tid;
  logic [tts_pkg::SemIdW-1:0] sem_index;
  logic signed [tts_pkg::CntW-1:0] init_count;
  logic [tts_pkg::ValW-1:0]   exit_value;
  modport source (output valid, func, target_tid, sem_index, init_count, exit_value,
                  input ready);
  modport sink (input valid, func, target_tid, sem_index, init_count, exit_value,
                output ready);
endinterface

interface tts_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [tts_pkg::StatW-1:0]  status;
  logic [tts_pkg::ValW-1:0]   result_value;
  logic                       switched;
  logic [tts_pkg::RslotW-1:0] running_slot;
  logic [tts_pkg::TidW-1:0]   running_tid;
  modport source (output valid, status, result_value, switched, running_slot,
                  running_tid, input ready);
  modport sink (input valid, status, result_value, switched, running_slot,
                running_tid, output ready);
endinterface
`default_nettype wire

// File: hdl/tts_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module tts_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: hdl/thread_table_scheduler_unit.sv
// Top level: thread slot table scheduler with counting semaphores.
//
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | func, target_tid, sem_index, init_count, exit_value
//  rsp     | out | valid/ready | status, result_value, switched, running_slot, running_tid
//
// One request at a time: accept, a slot scan (one slot table entry read per cycle),
// a wait queue RAM read, then a queue shift through the wait queue RAM that moves
// entries for a post with a wake and appends the waiter for a blocking wait, then a
// reschedule scan.
// Reset clears the state bank in flip-flops; the wait queue RAM is never cleared.
// The result is held in an output register until taken; ready is low outside idle.
`default_nettype none
module thread_table_scheduler_unit
  import tts_pkg::*;
#(
  parameter int MAX_SLOTS   = tts_pkg::MaxSlots,
  parameter int NUM_SEMS    = tts_pkg::NumSems,
  parameter int QUEUE_DEPTH = tts_pkg::QueueDepth,
  parameter int ID_WIDTH    = tts_pkg::IdWidth
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  tts_req_if.sink   req,
  tts_rsp_if.source rsp
);
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int MW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam int QA = $clog2(NUM_SEMS * QUEUE_DEPTH) > 0 ? $clog2(NUM_SEMS * QUEUE_DEPTH) : 1;
  localparam logic [ID_WIDTH-1:0] IdOne = ID_WIDTH'(1);

  // slot table: state in flops, id/waiter/return in flops (small), scanned a slot a cycle
  tstate_e            st_q  [MAX_SLOTS];
  logic [ID_WIDTH-1:0] id_q [MAX_SLOTS];
  logic               wv_q  [MAX_SLOTS];
  logic [ID_WIDTH-1:0] wid_q [MAX_SLOTS];
  logic [ValW-1:0]    ret_q [MAX_SLOTS];
  logic signed [CntW-1:0] cnt_q [NUM_SEMS];
  logic [LW-1:0]      qlen_q [NUM_SEMS];
  logic [SW-1:0]      cur_q, before_q;
  logic [ID_WIDTH-1:0] nid_q;

  fsm_e fsm_q, fsm_d;
  func_e          fn_q;
  logic [TidW-1:0] tgt_q;
  logic [SemIdW-1:0] si_q;
  logic [CntW-1:0] ic_q;
  logic [ValW-1:0] ev_q;
  logic [SW:0]     ix_q;
  logic            fnd_q;
  logic [SW-1:0]   fs_q;
  logic [ID_WIDTH-1:0] wake_q;
  logic            wakeen_q;
  logic [QW:0]     qi_q;
  status_e         stat_q;
  logic [ValW-1:0] res_q;
  logic            ovalid_q;
  logic [StatW-1:0] ost_q;
  logic [ValW-1:0] ores_q;
  logic            osw_q;
  logic [SW-1:0]   oslot_q;
  logic [ID_WIDTH-1:0] otid_q;

  // wait queue RAM
  logic            q_we;
  logic [QA-1:0]   q_wa, q_ra;
  logic [ID_WIDTH-1:0] q_wd, q_rd;
  tts_ram #(.Width(ID_WIDTH), .Depth(NUM_SEMS * QUEUE_DEPTH)) u_wq (
    .clk_i, .we_i(q_we), .waddr_i(q_wa), .wdata_i(q_wd), .raddr_i(q_ra), .rdata_o(q_rd)
  );

  logic [SW-1:0] six;
  logic [MW-1:0] sem;
  logic          sem_ok;
  logic signed [CntW-1:0] cdec, cinc;
  assign six    = ix_q[SW-1:0];
  assign sem    = MW'(si_q);
  assign sem_ok = 32'(si_q) < NUM_SEMS;
  assign cdec   = (cnt_q[sem] == -8'sd128) ? -8'sd128 : cnt_q[sem] - 8'sd1;
  assign cinc   = (cnt_q[sem] == 8'sd127) ? 8'sd127 : cnt_q[sem] + 8'sd1;

  function automatic logic [QA-1:0] qaddr(logic [MW-1:0] s, logic [QW:0] k);
    return QA'(32'(s) * QUEUE_DEPTH + 32'(k));
  endfunction

  assign req.ready        = (fsm_q == FS_IDLE);
  assign rsp.valid        = ovalid_q;
  assign rsp.status       = ost_q;
  assign rsp.result_value = ores_q;
  assign rsp.switched     = osw_q;
  assign rsp.running_slot = RslotW'(oslot_q);
  assign rsp.running_tid  = TidW'(otid_q);

  always_comb begin
    fsm_d = fsm_q;
    q_we = 1'b0; q_wa = qaddr(sem, qi_q); q_wd = id_q[cur_q];
    q_ra = qaddr(sem, '0);
    case (fsm_q)
      FS_IDLE:    if (req.valid) fsm_d = FS_SCAN;
      FS_SCAN:    if (ix_q == (SW+1)'(MAX_SLOTS - 1)) fsm_d = FS_QRD;
      FS_QRD:     fsm_d = FS_QSHIFT;
      FS_QSHIFT: begin
        q_ra = qaddr(sem, qi_q + 1'b1);
        q_wa = qaddr(sem, qi_q - 1'b1);
        q_wd = q_rd;
        q_we = (fn_q == FN_SPOST) && wakeen_q && (qi_q != 0) &&
               (32'(qi_q) < 32'(qlen_q[sem]));
        if (fn_q == FN_SWAIT && stat_q == ST_BLOCKED && qi_q == 0) begin
          q_we = 1'b1; q_wa = qaddr(sem, (QW+1)'(qlen_q[sem]) - 1'b1); q_wd = id_q[cur_q];
        end
        if (!(fn_q == FN_SPOST && wakeen_q) || 32'(qi_q) >= 32'(qlen_q[sem])) begin
          fsm_d = FS_RESCHED;
        end
      end
      FS_RESCHED: if (ix_q == (SW+1)'(MAX_SLOTS - 1)) fsm_d = FS_OUT;
      FS_OUT:     if (!ovalid_q || rsp.ready) fsm_d = FS_IDLE;
      default:    fsm_d = FS_IDLE;
    endcase
  end

  // round-robin pick after the current slot, current slot last; a wake of the
  // last scanned slot is not yet in st_q and counts as runnable here
  logic          rs_got;
  logic [SW-1:0] rs_n;
  logic [SW:0]   rs_t;
  logic          rs_do;
  always_comb begin
    rs_got = 1'b0; rs_n = cur_q; rs_t = '0;
    for (int k = 1; k <= MAX_SLOTS; k++) begin
      rs_t = {1'b0, cur_q} + (SW+1)'(k);
      if (rs_t >= (SW+1)'(MAX_SLOTS)) rs_t = rs_t - (SW+1)'(MAX_SLOTS);
      if (!rs_got && (st_q[rs_t[SW-1:0]] == TS_RUNNABLE ||
          (wakeen_q && !fnd_q && rs_t[SW-1:0] == six &&
           st_q[rs_t[SW-1:0]] == TS_SLEEPING && id_q[rs_t[SW-1:0]] == wake_q))) begin
        rs_got = 1'b1; rs_n = rs_t[SW-1:0];
      end
    end
    rs_do = (fsm_q == FS_RESCHED) && (fsm_d != FS_RESCHED) && rs_got &&
            (fn_q == FN_YIELD || fn_q == FN_EXIT || stat_q == ST_BLOCKED);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= FS_IDLE;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        st_q[i] <= (i == 0) ? TS_RUNNING : TS_UNUSED;
        id_q[i] <= '0; wv_q[i] <= 1'b0; wid_q[i] <= '0; ret_q[i] <= '0;
      end
      for (int i = 0; i < NUM_SEMS; i++) begin
        cnt_q[i] <= '0; qlen_q[i] <= '0;
      end
      cur_q <= '0; before_q <= '0; nid_q <= IdOne;
      ix_q <= '0; fnd_q <= 1'b0; fs_q <= '0; wakeen_q <= 1'b0; wake_q <= '0;
      qi_q <= '0; stat_q <= ST_OK; res_q <= '0; fn_q <= FN_NOP;
      tgt_q <= '0; si_q <= '0; ic_q <= '0; ev_q <= '0;
      ovalid_q <= 1'b0; ost_q <= ST_OK; ores_q <= '0; osw_q <= 1'b0;
      oslot_q <= '0; otid_q <= '0;
    end else begin
      fsm_q <= fsm_d;
      if (fsm_q == FS_OUT && (!ovalid_q || rsp.ready)) ovalid_q <= 1'b1;
      else if (rsp.ready) ovalid_q <= 1'b0;
      case (fsm_q)
        FS_IDLE: if (req.valid) begin
          fn_q <= func_e'(req.func); tgt_q <= req.target_tid; si_q <= req.sem_index;
          ic_q <= req.init_count; ev_q <= req.exit_value;
          ix_q <= '0; fnd_q <= 1'b0; stat_q <= ST_OK; res_q <= '0;
          before_q <= cur_q; wakeen_q <= 1'b0; qi_q <= '0;
        end
        FS_SCAN: begin
          // find first unused (create) or lowest live slot with matching id (join)
          if (!fnd_q) begin
            if (fn_q == FN_CREATE && st_q[six] == TS_UNUSED) begin
              fnd_q <= 1'b1; fs_q <= six;
            end
            if (fn_q == FN_JOIN && st_q[six] != TS_UNUSED &&
                id_q[six] == ID_WIDTH'(tgt_q)) begin
              fnd_q <= 1'b1; fs_q <= six;
            end
          end
          if (fsm_d == FS_SCAN) ix_q <= ix_q + 1'b1;
          else begin
            ix_q <= '0;
            case (fn_q)
              FN_CREATE: begin
                if (fnd_q) begin
                  id_q[fs_q] <= nid_q; st_q[fs_q] <= TS_RUNNABLE; ret_q[fs_q] <= '0;
                  wv_q[fs_q] <= 1'b0; wid_q[fs_q] <= '0; res_q <= ValW'(nid_q);
                  nid_q <= (nid_q + 1'b1 == '0) ? IdOne : nid_q + 1'b1;
                end else if (st_q[six] == TS_UNUSED) begin
                  id_q[six] <= nid_q; st_q[six] <= TS_RUNNABLE; ret_q[six] <= '0;
                  wv_q[six] <= 1'b0; wid_q[six] <= '0; res_q <= ValW'(nid_q);
                  nid_q <= (nid_q + 1'b1 == '0) ? IdOne : nid_q + 1'b1;
                end else stat_q <= ST_NO_SLOT;
              end
              FN_EXIT: begin
                ret_q[cur_q] <= ev_q; st_q[cur_q] <= TS_ZOMBIE;
                wakeen_q <= wv_q[cur_q]; wake_q <= wid_q[cur_q];
              end
              FN_JOIN: begin : jn
                logic hit;
                logic [SW-1:0] s;
                hit = fnd_q; s = fs_q;
                if (!fnd_q && st_q[six] != TS_UNUSED && id_q[six] == ID_WIDTH'(tgt_q)) begin
                  hit = 1'b1; s = six;
                end
                if (!hit) stat_q <= ST_NOT_FOUND;
                else if (st_q[s] == TS_ZOMBIE) begin
                  res_q <= ret_q[s]; st_q[s] <= TS_UNUSED; id_q[s] <= '0;
                  wv_q[s] <= 1'b0; wid_q[s] <= '0;
                end else begin
                  st_q[cur_q] <= TS_SLEEPING; wv_q[s] <= 1'b1;
                  wid_q[s] <= (s == cur_q) ? id_q[cur_q] : id_q[cur_q];
                  stat_q <= ST_BLOCKED;
                end
              end
              FN_SINIT: if (sem_ok) begin
                cnt_q[sem] <= ic_q; qlen_q[sem] <= '0;
              end
              FN_SWAIT: if (sem_ok) begin
                if (cdec < 0) begin
                  if (32'(qlen_q[sem]) >= QUEUE_DEPTH) stat_q <= ST_QFULL;
                  else begin
                    cnt_q[sem] <= cdec; qlen_q[sem] <= qlen_q[sem] + 1'b1;
                    st_q[cur_q] <= TS_SLEEPING; stat_q <= ST_BLOCKED;
                  end
                end else cnt_q[sem] <= cdec;
              end
              FN_SPOST: if (sem_ok) begin
                cnt_q[sem] <= cinc;
                if (cinc <= 0 && qlen_q[sem] != 0) wakeen_q <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        FS_QRD: qi_q <= '0;
        FS_QSHIFT: begin
          if (fn_q == FN_SPOST && wakeen_q && qi_q == 0) wake_q <= q_rd;
          qi_q <= qi_q + 1'b1;
          if (fsm_d != FS_QSHIFT && fn_q == FN_SPOST && wakeen_q)
            qlen_q[sem] <= qlen_q[sem] - 1'b1;
          ix_q <= '0; fnd_q <= 1'b0;
        end
        FS_RESCHED: begin
          // wake pass folded in: lowest live slot with the id, if sleeping
          if (wakeen_q && !fnd_q && st_q[six] != TS_UNUSED && id_q[six] == wake_q) begin
            fnd_q <= 1'b1;
            if (st_q[six] == TS_SLEEPING && !(rs_do && rs_n == six))
              st_q[six] <= TS_RUNNABLE;
          end
          if (fsm_d == FS_RESCHED) ix_q <= ix_q + 1'b1;
          else ix_q <= '0;
          if (rs_do) begin
            if (st_q[cur_q] == TS_RUNNING && rs_n != cur_q) st_q[cur_q] <= TS_RUNNABLE;
            st_q[rs_n] <= TS_RUNNING; cur_q <= rs_n;
          end
        end
        FS_OUT: if (!ovalid_q || rsp.ready) begin
          ost_q <= stat_q; ores_q <= res_q;
          osw_q <= (cur_q != before_q); oslot_q <= cur_q; otid_q <= id_q[cur_q];
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> fsm_q == FS_IDLE) else $error("ready outside idle");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status) &&
    $stable(rsp.result_value) && $stable(rsp.running_tid))
    else $error("result changed while stalled");
  a_qlen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(qlen_q[sem]) <= QUEUE_DEPTH) else $error("queue overflow");
`endif
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Testbench for the thread table scheduler: directed table plus random requests.
`timescale 1ns / 100ps
module tb_top;
  import tts_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tts_req_if req ();
  tts_rsp_if rsp ();

  thread_table_scheduler_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req.sink), .rsp(rsp.source)
  );

  typedef struct packed {
    func_e       func;
    logic [15:0] tid;
    logic [2:0]  sem;
    logic [7:0]  cnt;
    logic [31:0] ev;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] value;
    logic        switched;
    logic [2:0]  rslot;
    logic [15:0] rtid;
  } rsp_t;

  // shadow scheduler state
  tstate_e     th_state [MaxSlots];
  logic [15:0] th_id    [MaxSlots];
  logic [16:0] th_waiter[MaxSlots];
  logic [31:0] th_ret   [MaxSlots];
  int          cur_slot;
  logic [15:0] id_next;
  int          sem_cnt  [NumSems];
  logic [15:0] sem_q    [NumSems][QueueDepth];
  int          sem_len  [NumSems];

  rsp_t pending_rsp[$];
  int   errors = 0;
  int   n_items = 0, n_rsp = 0, n_blocked = 0, n_switch = 0;
  int   cycles = 0;
  int   snd_idle = 15, rcv_idle = 70;
  int   rcv_hold = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  function automatic int lookup_slot(logic [15:0] id);
    for (int i = 0; i < MaxSlots; i++)
      if (th_state[i] != TS_UNUSED && th_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void wake_id(logic [15:0] id);
    int s;
    s = lookup_slot(id);
    if (s >= 0 && th_state[s] == TS_SLEEPING) th_state[s] = TS_RUNNABLE;
  endfunction

  function automatic void pick_next();
    int k;
    for (int i = 0; i < MaxSlots; i++) begin
      k = (cur_slot + 1 + i) % MaxSlots;
      if (th_state[k] == TS_RUNNABLE) begin
        if (th_state[cur_slot] == TS_RUNNING) th_state[cur_slot] = TS_RUNNABLE;
        th_state[k] = TS_RUNNING;
        cur_slot = k;
        return;
      end
    end
  endfunction

  function automatic void sched_reset();
    for (int i = 0; i < MaxSlots; i++) begin
      th_state[i] = TS_UNUSED; th_id[i] = '0; th_waiter[i] = '0; th_ret[i] = '0;
    end
    for (int i = 0; i < NumSems; i++) begin
      sem_cnt[i] = 0; sem_len[i] = 0;
    end
    th_state[0] = TS_RUNNING;
    cur_slot = 0;
    id_next = 16'd1;
  endfunction

  function automatic rsp_t sched_predict(req_t r);
    rsp_t o;
    int   prev, s, c, fs;
    o = '0;
    o.status = ST_OK;
    prev = cur_slot;
    case (r.func)
      FN_CREATE: begin
        fs = -1;
        for (int i = 0; i < MaxSlots; i++)
          if (fs < 0 && th_state[i] == TS_UNUSED) fs = i;
        if (fs < 0) o.status = ST_NO_SLOT;
        else begin
          th_id[fs] = id_next; th_state[fs] = TS_RUNNABLE;
          th_ret[fs] = '0; th_waiter[fs] = '0;
          o.value = 32'(id_next);
          id_next = id_next + 16'd1;
          if (id_next == 16'd0) id_next = 16'd1;
        end
      end
      FN_YIELD: pick_next();
      FN_EXIT: begin
        th_ret[cur_slot] = r.ev;
        th_state[cur_slot] = TS_ZOMBIE;
        if (th_waiter[cur_slot][16]) wake_id(th_waiter[cur_slot][15:0]);
        pick_next();
      end
      FN_JOIN: begin
        s = lookup_slot(r.tid);
        if (s < 0) o.status = ST_NOT_FOUND;
        else if (th_state[s] == TS_ZOMBIE) begin
          o.value = th_ret[s];
          th_state[s] = TS_UNUSED; th_id[s] = '0; th_waiter[s] = '0;
        end else begin
          th_state[cur_slot] = TS_SLEEPING;
          th_waiter[s] = {1'b1, th_id[cur_slot]};
          pick_next();
          o.status = ST_BLOCKED;
        end
      end
      FN_SINIT: begin
        sem_cnt[r.sem] = int'($signed(r.cnt));
        sem_len[r.sem] = 0;
      end
      FN_SWAIT: begin
        c = sem_cnt[r.sem] > -128 ? sem_cnt[r.sem] - 1 : -128;
        if (c < 0) begin
          if (sem_len[r.sem] >= QueueDepth) o.status = ST_QFULL;
          else begin
            sem_cnt[r.sem] = c;
            sem_q[r.sem][sem_len[r.sem]] = th_id[cur_slot];
            sem_len[r.sem]++;
            th_state[cur_slot] = TS_SLEEPING;
            pick_next();
            o.status = ST_BLOCKED;
          end
        end else sem_cnt[r.sem] = c;
      end
      FN_SPOST: begin
        if (sem_cnt[r.sem] < 127) sem_cnt[r.sem]++;
        if (sem_cnt[r.sem] <= 0 && sem_len[r.sem] > 0) begin
          c = int'(sem_q[r.sem][0]);
          for (int i = 1; i < sem_len[r.sem]; i++) sem_q[r.sem][i-1] = sem_q[r.sem][i];
          sem_len[r.sem]--;
          wake_id(16'(c));
        end
      end
      default: ;
    endcase
    o.switched = (cur_slot != prev);
    o.rslot = 3'(cur_slot);
    o.rtid = th_id[cur_slot];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("MISMATCH %s at item %0d: got %0h expected %0h", what, n_rsp, got, exp);
    errors++;
  endtask

  task automatic send_req(req_t r);
    while ($urandom_range(99) < snd_idle) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.func <= r.func; req.target_tid <= r.tid; req.sem_index <= r.sem;
    req.init_count <= r.cnt; req.exit_value <= r.ev;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    pending_rsp.push_back(sched_predict(r));
    n_items++;
  endtask

  // typed expectation for directed rows where it is plain
  task automatic send_known(req_t r, rsp_t e);
    rsp_t p;
    send_req(r);
    p = pending_rsp[$];
    if (p != e) report_mismatch("directed expectation", 32'(p), 32'(e));
  endtask

  function automatic req_t mk(func_e f, logic [15:0] t, logic [2:0] s,
                              logic [7:0] c, logic [31:0] v);
    req_t r;
    r.func = f; r.tid = t; r.sem = s; r.cnt = c; r.ev = v;
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int   k;
    r = mk(FN_YIELD, 16'($urandom), 3'($urandom), 8'($urandom), $urandom);
    k = $urandom_range(99);
    if (k < 22) r.func = FN_CREATE;
    else if (k < 34) r.func = FN_YIELD;
    else if (k < 46) r.func = FN_EXIT;
    else if (k < 62) r.func = FN_JOIN;
    else if (k < 68) r.func = FN_SINIT;
    else if (k < 82) r.func = FN_SWAIT;
    else if (k < 98) r.func = FN_SPOST;
    else r.func = FN_NOP;
    // mostly join live ids
    if (r.func == FN_JOIN && $urandom_range(3) != 0)
      r.tid = th_id[$urandom_range(MaxSlots-1)];
    if (r.func == FN_SINIT && $urandom_range(3) != 0) r.cnt = 8'($urandom_range(3));
    if (r.func == FN_SWAIT || r.func == FN_SPOST) r.sem = 3'($urandom_range(2));
    return r;
  endfunction

  // result sink and checker
  always @(posedge clk_i) begin
    rsp_t e;
    cycles++;
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      rcv_hold = 300;
    end
    if (rcv_hold > 0) begin
      rsp.ready <= 1'b0;
      rcv_hold--;
    end else rsp.ready <= ($urandom_range(99) >= rcv_idle);
    if (rst_ni && rsp.valid && rsp.ready) begin
      n_rsp++;
      if (pending_rsp.size() == 0) begin
        $display("MISMATCH unexpected result at item %0d", n_rsp);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.status != e.status)
          report_mismatch("status", 32'(rsp.status), 32'(e.status));
        if (rsp.result_value != e.value)
          report_mismatch("result_value", rsp.result_value, e.value);
        if (rsp.switched != e.switched)
          report_mismatch("switched", 32'(rsp.switched), 32'(e.switched));
        if (rsp.running_slot != e.rslot)
          report_mismatch("running_slot", 32'(rsp.running_slot), 32'(e.rslot));
        if (rsp.running_tid != e.rtid)
          report_mismatch("running_tid", 32'(rsp.running_tid), 32'(e.rtid));
        if (e.status == ST_BLOCKED) n_blocked++;
        if (e.switched) n_switch++;
      end
    end
    if (cycles > 600000) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rsp_t e;
    req.valid = 1'b0; req.func = '0; req.target_tid = '0; req.sem_index = '0;
    req.init_count = '0; req.exit_value = '0;
    sched_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    e = '0; e.status = ST_OK;
    send_known(mk(FN_YIELD, 0, 0, 0, 0), e);
    e.status = ST_NOT_FOUND;
    send_known(mk(FN_JOIN, 16'hFFFF, 0, 0, 0), e);
    e = '0; e.status = ST_OK; e.value = 32'd1;
    send_known(mk(FN_CREATE, 0, 0, 0, 0), e);
    for (int i = 0; i < 7; i++) send_req(mk(FN_CREATE, 0, 0, 0, 0));
    send_req(mk(FN_JOIN, 16'd1, 0, 0, 0));          // blocks
    send_req(mk(FN_EXIT, 0, 0, 0, 32'hFFFF_FFFF));  // wakes joiner
    send_req(mk(FN_YIELD, 0, 0, 0, 0));
    send_req(mk(FN_JOIN, 16'd1, 0, 0, 0));          // reissued join
    send_req(mk(FN_SINIT, 0, 3'd7, 8'h7F, 0));
    send_req(mk(FN_SPOST, 0, 3'd7, 0, 0));          // saturates at 127
    send_req(mk(FN_SINIT, 0, 3'd1, 8'h80, 0));
    send_req(mk(FN_SWAIT, 0, 3'd1, 0, 0));          // saturates low, blocks
    send_req(mk(FN_SPOST, 0, 3'd1, 0, 0));
    send_req(mk(FN_SINIT, 0, 3'd2, 8'h00, 0));
    for (int i = 0; i < 9; i++) send_req(mk(FN_SWAIT, 0, 3'd2, 0, 0)); // fills queue
    for (int i = 0; i < 9; i++) send_req(mk(FN_SPOST, 0, 3'd2, 0, 0));
    send_req(mk(FN_NOP, 16'hFFFF, 3'd7, 8'hFF, 32'h5A5A_A5A5));

    // long receiver stall while requests keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) send_req(rand_req());

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 15 : (ph == 1) ? 70 : 0;
      rcv_idle = (ph == 0) ? 70 : (ph == 1) ? 15 : 0;
      for (int i = 0; i < 520; i++) begin
        // push the id counter toward its wrap once, in the first phase
        if (i == 260 && ph == 0)
          for (int j = 0; j < 40; j++) send_req(mk(FN_CREATE, 0, 0, 0, 0));
        send_req(rand_req());
      end
      // sender pauses until everything is back
      req.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clk_i);
    end

    repeat (60) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d results (%0d blocked, %0d switches)",
             n_items, n_rsp, n_blocked, n_switch);
    if (errors == 0 && pending_rsp.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// File: sim.f
hdl/tts_pkg.sv
hdl/tts_if.sv
hdl/tts_ram.sv
hdl/thread_table_scheduler_unit.sv
tb/tb_top.sv
